// ----- src/lru_pkg.sv -----
`timescale 1ns / 1ps

package lru_pkg;

  // frames_in_use register
  localparam int          CFG_W          = 5;
  localparam logic [4:0]  FRAMES_RESET   = 5'd4;
  localparam int          FAULT_W        = 32;

  // APB register file
  localparam int          APB_ADDR_W     = 3;
  localparam int          APB_DATA_W     = 32;
  localparam logic [0:0]  REG_FRAMES_IDX = 1'b0;

  // store command for one cycle
  typedef struct packed {
    logic step;       // process the reference in the input register
    logic seq_end;    // clear store after this reference
    logic cfg_clear;  // register write: clear store
  } lru_ctl_t;

  // per-reference outcome flags
  typedef struct packed {
    logic hit;
    logic evicted_valid;
  } lru_status_t;

endpackage

// ----- src/lru_chan_if.sv -----
`timescale 1ns / 1ps

interface lru_req_if #(
  parameter int PAGE_BITS = 16
) ();
  logic                 valid;
  logic                 ready;
  logic [PAGE_BITS-1:0] page_number;
  logic                 last_reference;

  modport source (output valid, page_number, last_reference, input ready);
  modport sink   (input valid, page_number, last_reference, output ready);
endinterface

interface lru_rsp_if #(
  parameter int PAGE_BITS = 16,
  parameter int SLOT_W    = 4
) ();
  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic [SLOT_W-1:0]    frame_slot;
  logic                 evicted_valid;
  logic [PAGE_BITS-1:0] evicted_page;
  logic [31:0]          fault_count;
  logic                 sequence_end;

  modport source (output valid, hit, frame_slot, evicted_valid, evicted_page,
                  fault_count, sequence_end, input ready);
  modport sink   (input valid, hit, frame_slot, evicted_valid, evicted_page,
                  fault_count, sequence_end, output ready);
endinterface

// ----- src/lru_apb_regs.sv -----
`timescale 1ns / 1ps

module lru_apb_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lru_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [lru_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [lru_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready,
  output logic [lru_pkg::CFG_W-1:0]         frames_in_use,
  output logic                              cfg_clear
);
  import lru_pkg::*;

  logic [CFG_W-1:0] frames_r, frames_nxt;
  logic             wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_FRAMES_IDX);

  always_comb begin
    frames_nxt = frames_r;
    if (wr_hit) begin
      frames_nxt = pwdata[CFG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_r <= FRAMES_RESET;
    end else begin
      frames_r <= frames_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_FRAMES_IDX) begin
      prdata = {{(APB_DATA_W-CFG_W){1'b0}}, frames_r};
    end
  end

  assign frames_in_use = frames_r;
  assign cfg_clear     = wr_hit;

endmodule

// ----- src/lru_frame_store.sv -----
`timescale 1ns / 1ps

module lru_frame_store #(
  parameter int FRAME_SLOTS = 16,
  parameter int PAGE_BITS   = 16,
  parameter int SLOT_W      = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [lru_pkg::CFG_W-1:0]   frames_in_use,
  input  lru_pkg::lru_ctl_t           ctl,
  input  logic [PAGE_BITS-1:0]        page,
  output lru_pkg::lru_status_t        status,
  output logic [SLOT_W-1:0]           slot,
  output logic [PAGE_BITS-1:0]        evicted_page,
  output logic [lru_pkg::FAULT_W-1:0] fault_count
);
  import lru_pkg::*;

  localparam int CNT_W = $clog2(FRAME_SLOTS + 1);

  logic [PAGE_BITS-1:0]   page_r   [FRAME_SLOTS];
  logic [PAGE_BITS-1:0]   page_nxt [FRAME_SLOTS];
  logic [SLOT_W-1:0]      rank_r   [FRAME_SLOTS];
  logic [SLOT_W-1:0]      rank_nxt [FRAME_SLOTS];
  logic [FRAME_SLOTS-1:0] valid_r, valid_nxt;
  logic [FAULT_W-1:0]     fault_r, fault_nxt, fault_inc;

  logic [CNT_W-1:0]       n_eff;
  logic [SLOT_W-1:0]      oldest_rank;
  logic [FRAME_SLOTS-1:0] active, match, empty, victim;
  logic [SLOT_W-1:0]      hit_slot, empty_slot, victim_slot, sel_slot;
  logic                   hit, any_empty, evict;
  logic [SLOT_W-1:0]      old_rank;

  // effective frame count, clamped to 1..FRAME_SLOTS
  always_comb begin
    if (frames_in_use == '0) begin
      n_eff = CNT_W'(1);
    end else if (int'(frames_in_use) > FRAME_SLOTS) begin
      n_eff = CNT_W'(FRAME_SLOTS);
    end else begin
      n_eff = CNT_W'(frames_in_use);
    end
    oldest_rank = SLOT_W'(n_eff - CNT_W'(1));
  end

  // parallel tag compare; ranks of valid frames form a permutation,
  // so the victim is the one frame whose rank is n_eff-1
  always_comb begin
    for (int i = 0; i < FRAME_SLOTS; i++) begin
      active[i] = (CNT_W'(i) < n_eff);
      match[i]  = valid_r[i] && active[i] && (page_r[i] == page);
      empty[i]  = !valid_r[i] && active[i];
      victim[i] = valid_r[i] && active[i] && (rank_r[i] == oldest_rank);
    end
  end

  always_comb begin
    hit_slot    = '0;
    empty_slot  = '0;
    victim_slot = '0;
    for (int i = FRAME_SLOTS - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_slot = SLOT_W'(i);
      end
      if (empty[i]) begin
        empty_slot = SLOT_W'(i);
      end
      if (victim[i]) begin
        victim_slot = SLOT_W'(i);
      end
    end
  end

  assign hit       = |match;
  assign any_empty = |empty;
  assign evict     = !hit && !any_empty;

  always_comb begin
    if (hit) begin
      sel_slot = hit_slot;
    end else if (any_empty) begin
      sel_slot = empty_slot;
    end else begin
      sel_slot = victim_slot;
    end
    old_rank = rank_r[sel_slot];
  end

  assign fault_inc = (fault_r != '1) ? fault_r + FAULT_W'(1) : fault_r;

  always_comb begin
    valid_nxt = valid_r;
    fault_nxt = fault_r;
    for (int i = 0; i < FRAME_SLOTS; i++) begin
      page_nxt[i] = page_r[i];
      rank_nxt[i] = rank_r[i];
    end
    if (ctl.step) begin
      for (int i = 0; i < FRAME_SLOTS; i++) begin
        if (SLOT_W'(i) == sel_slot) begin
          rank_nxt[i]  = '0;
          valid_nxt[i] = 1'b1;
          if (!hit) begin
            page_nxt[i] = page;
          end
        end else if (valid_r[i]) begin
          // a fill ages every resident frame; hit/evict only the younger ones
          if ((hit || evict) ? (rank_r[i] < old_rank) : 1'b1) begin
            rank_nxt[i] = rank_r[i] + SLOT_W'(1);
          end
        end
      end
      if (!hit) begin
        fault_nxt = fault_inc;
      end
    end
    if (ctl.cfg_clear || (ctl.step && ctl.seq_end)) begin
      valid_nxt = '0;
      fault_nxt = '0;
      for (int i = 0; i < FRAME_SLOTS; i++) begin
        rank_nxt[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      fault_r <= '0;
      for (int i = 0; i < FRAME_SLOTS; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      valid_r <= valid_nxt;
      fault_r <= fault_nxt;
      for (int i = 0; i < FRAME_SLOTS; i++) begin
        rank_r[i] <= rank_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < FRAME_SLOTS; i++) begin
      page_r[i] <= page_nxt[i];
    end
  end

  assign status.hit           = hit;
  assign status.evicted_valid = evict;
  assign slot                 = sel_slot;
  assign evicted_page         = evict ? page_r[victim_slot] : '0;
  assign fault_count          = hit ? fault_r : fault_inc;

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.cfg_clear |=> (valid_r == '0) && (fault_r == '0))
    else $error("store not cleared after register write");

  a_valid_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r & ~active) == '0)
    else $error("valid frame outside frames in use");

  a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.step |-> $onehot0(match))
    else $error("page resident in more than one frame");

  a_one_victim: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.step && evict) |-> $onehot(victim))
    else $error("no unique LRU victim on a full store");

endmodule

// ----- src/lru_page_replacement_unit.sv -----
`timescale 1ns / 1ps
// Channel  | Ports                         | Transaction
// ---------+-------------------------------+-------------------------------------
// in_chan  | valid/ready, page_number,     | one page reference
//          | last_reference                |
// out_chan | valid/ready, hit, frame_slot, | one result per reference
//          | evicted_*, fault_count, ...   |
// cfg      | psel/penable/pwrite/paddr/... | APB write of frames_in_use (addr 0)
//
// One reference per cycle while out_chan does not stall: input register -> CAM
// compare and rank update over all frames -> result register.
// Reset (rst_n low, synchronous) empties all frames and zeroes the fault count.
// A stall on out_chan holds the result register and the input register;
// in_chan.ready stays high while either register can move.

module lru_page_replacement_unit #(
  parameter int FRAME_SLOTS = 16,
  parameter int PAGE_BITS   = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  lru_req_if.sink                        in_chan,
  lru_rsp_if.source                      out_chan,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lru_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [lru_pkg::APB_DATA_W-1:0] pwdata,
  output logic [lru_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import lru_pkg::*;

  localparam int SLOT_W = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;

  logic                 in_valid_r, in_valid_nxt;
  logic [PAGE_BITS-1:0] in_page_r;
  logic                 in_last_r;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_hit_r, out_ev_valid_r, out_last_r;
  logic [SLOT_W-1:0]    out_slot_r;
  logic [PAGE_BITS-1:0] out_ev_page_r;
  logic [FAULT_W-1:0]   out_fault_r;

  logic                 advance, take_in, cfg_clear;
  logic [CFG_W-1:0]     frames_in_use;
  lru_ctl_t             ctl;
  lru_status_t          status;
  logic [SLOT_W-1:0]    slot;
  logic [PAGE_BITS-1:0] evicted_page;
  logic [FAULT_W-1:0]   fault_count;

  lru_apb_regs u_regs (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .frames_in_use (frames_in_use),
    .cfg_clear     (cfg_clear)
  );

  assign advance        = !out_valid_r || out_chan.ready;
  assign in_chan.ready  = !in_valid_r || advance;
  assign take_in        = in_chan.valid && in_chan.ready;

  assign ctl.step      = in_valid_r && advance;
  assign ctl.seq_end   = in_last_r;
  assign ctl.cfg_clear = cfg_clear;

  lru_frame_store #(
    .FRAME_SLOTS (FRAME_SLOTS),
    .PAGE_BITS   (PAGE_BITS),
    .SLOT_W      (SLOT_W)
  ) u_store (
    .clk           (clk),
    .rst_n         (rst_n),
    .frames_in_use (frames_in_use),
    .ctl           (ctl),
    .page          (in_page_r),
    .status        (status),
    .slot          (slot),
    .evicted_page  (evicted_page),
    .fault_count   (fault_count)
  );

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (take_in) begin
      in_valid_nxt = 1'b1;
    end else if (ctl.step) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (ctl.step) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      in_page_r <= in_chan.page_number;
      in_last_r <= in_chan.last_reference;
    end
    if (ctl.step) begin
      out_hit_r      <= status.hit;
      out_ev_valid_r <= status.evicted_valid;
      out_slot_r     <= slot;
      out_ev_page_r  <= evicted_page;
      out_fault_r    <= fault_count;
      out_last_r     <= in_last_r;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.hit           = out_hit_r;
  assign out_chan.frame_slot    = out_slot_r;
  assign out_chan.evicted_valid = out_ev_valid_r;
  assign out_chan.evicted_page  = out_ev_page_r;
  assign out_chan.fault_count   = out_fault_r;
  assign out_chan.sequence_end  = out_last_r;

  a_step_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.step |=> out_valid_r)
    else $error("processed reference produced no result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_chan.ready) |-> !ctl.step)
    else $error("result overwritten while stalled");

  a_fault_on_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ev_valid_r) |-> !out_hit_r)
    else $error("eviction reported on a hit");

endmodule
